>>> design/satl_pkg.sv
package satl_pkg;

  // Address width of an access; tags are kept at full address width.
  localparam int ADDR_W = 32;

  // Default geometry handed to the top level.
  localparam int DEF_SETS = 64;
  localparam int DEF_WAYS = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_INDEX_BITS  = 2'd1,
    REG_WAYS_IN_USE = 2'd2
  } cfg_reg_t;

  // Register widths and reset values.
  localparam int OFFSET_W = 5;
  localparam int INDEX_W  = 3;
  localparam int WAYSCF_W = 3;

  localparam logic [OFFSET_W-1:0] OFFSET_RST = 5'd2;
  localparam logic [INDEX_W-1:0]  INDEX_RST  = 3'd6;
  localparam logic [WAYSCF_W-1:0] WAYS_RST   = 3'd4;

  // Outcome of one lookup.
  typedef struct packed {
    logic hit;
    logic dirty_evict;
  } satl_res_t;

  // Largest n with 2**n <= sets; evaluated at elaboration only.
  function automatic int floor_log2(input int sets);
    int n;
    n = 0;
    while ((n < 31) && ((1 << (n + 1)) <= sets)) begin
      n = n + 1;
    end
    return n;
  endfunction

endpackage

>>> design/satl_ram.sv
module satl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 134,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/satl_way_match.sv
module satl_way_match #(
  parameter int WAYS = 4,
  parameter int WW   = 2,
  parameter int CW   = 3
) (
  input  logic [WAYS-1:0][satl_pkg::ADDR_W-1:0] tags,
  input  logic [WAYS-1:0]                       dirty,
  input  logic [WW-1:0]                         victim,
  input  logic [satl_pkg::ADDR_W-1:0]           tag,
  input  logic                                  store,
  input  logic [CW-1:0]                         ways,
  output logic [WAYS-1:0][satl_pkg::ADDR_W-1:0] tags_new,
  output logic [WAYS-1:0]                       dirty_new,
  output logic [WW-1:0]                         victim_new,
  output satl_pkg::satl_res_t                   res
);

  import satl_pkg::*;

  logic          hit;
  logic [WW-1:0] hit_way;
  logic [WW-1:0] victim_eff;
  logic [WW-1:0] touched;
  logic [CW:0]   touched_inc;

  // Lowest matching way among those in use wins: scan from the top down.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if ((CW'(w) < ways) && (tags[w] == tag)) begin
        hit     = 1'b1;
        hit_way = WW'(w);
      end
    end
  end

  // A pointer left beyond the ways in use falls back to way 0.
  assign victim_eff = (CW'(victim) >= ways) ? '0 : victim;
  assign touched    = hit ? hit_way : victim_eff;

  // Store hit sets dirty; a fill replaces the tag and takes the store flag as dirty.
  always_comb begin
    tags_new  = tags;
    dirty_new = dirty;
    if (hit) begin
      if (store) begin
        dirty_new[touched] = 1'b1;
      end
    end else begin
      tags_new[touched]  = tag;
      dirty_new[touched] = store;
    end
  end

  // Pointer moves to the way after the one touched, wrapping at the ways in use.
  assign touched_inc = (CW + 1)'(touched) + (CW + 1)'(1);
  assign victim_new  = (touched_inc < (CW + 1)'(ways)) ? WW'(touched_inc) : '0;

  assign res.hit         = hit;
  assign res.dirty_evict = !hit && dirty[touched];

endmodule

>>> design/set_assoc_cache_tag_lookup.sv
// Tag store of a set-associative write-back cache. Each word on the input
// channel is one access (byte address in in_tdata, store flag in in_tuser);
// each produces one result word carrying hit and dirty-eviction flags. The
// tags, dirty bits and victim pointer of a set live together in one row of a
// synchronous memory, so an access reads the row when accepted and then, in
// ST_LOOK, compares, updates and writes it back; no new access is taken
// until that write-back, which waits while the output register holds a result
// not yet taken. A finished result sits in that register, so the next access
// is taken while it waits. After reset the block clears the memory one row a
// cycle and accepts no access until done; configuration writes are taken at
// any time but must only be made while the block is idle.
module set_assoc_cache_tag_lookup #(
  parameter int SETS = satl_pkg::DEF_SETS,
  parameter int WAYS = satl_pkg::DEF_WAYS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel: tdata = addr[31:0]; tuser = func (1 = store).
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [satl_pkg::ADDR_W-1:0]     in_tdata,
  input  logic                            in_tuser,
  // Result channel: tdata = hit[0], dirty_eviction[1], zero fill above.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [satl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [satl_pkg::CFG_DATA_W-1:0] cfg_data
);

  import satl_pkg::*;

  localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW  = $clog2(WAYS + 1);
  localparam int LIM = floor_log2(SETS);
  localparam int TW  = WAYS * ADDR_W;
  localparam int RW  = TW + WAYS + WW;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [SW-1:0]            clr_idx_r, clr_idx_nxt;
  logic [OFFSET_W-1:0]      offset_bits_r;
  logic [INDEX_W-1:0]       index_bits_r;
  logic [WAYSCF_W-1:0]      ways_in_use_r;
  logic [SW-1:0]            set_r;
  logic [ADDR_W-1:0]        tag_r;
  logic                     store_r;
  logic                     out_valid_r;
  satl_res_t                out_res_r;

  logic [3:0]               ib_eff;
  logic [CW-1:0]            ways_eff;
  logic [ADDR_W-1:0]        addr_sh;
  logic [ADDR_W-1:0]        set_mask;
  logic [5:0]               tag_sh;
  logic [SW-1:0]            set_calc;
  logic [ADDR_W-1:0]        tag_calc;
  logic                     in_acc;
  logic                     look_done;

  logic                     ram_we;
  logic [SW-1:0]            ram_waddr;
  logic [RW-1:0]            ram_wdata;
  logic [RW-1:0]            ram_rdata;

  logic [WAYS-1:0][ADDR_W-1:0] row_tags, new_tags;
  logic [WAYS-1:0]             row_dirty, new_dirty;
  logic [WW-1:0]               row_victim, new_victim;
  satl_res_t                   look_res;

  // Configuration registers; indexes beyond the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= OFFSET_RST;
      index_bits_r  <= INDEX_RST;
      ways_in_use_r <= WAYS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET_BITS: offset_bits_r <= cfg_data[OFFSET_W-1:0];
        REG_INDEX_BITS:  index_bits_r  <= cfg_data[INDEX_W-1:0];
        REG_WAYS_IN_USE: ways_in_use_r <= cfg_data[WAYSCF_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp index width to the sets built and associativity to 1..WAYS.
  assign ib_eff = ({1'b0, index_bits_r} > 4'(LIM)) ? 4'(LIM) : {1'b0, index_bits_r};

  always_comb begin
    if (ways_in_use_r == '0) begin
      ways_eff = CW'(1);
    end else if (6'(ways_in_use_r) > 6'(WAYS)) begin
      ways_eff = CW'(WAYS);
    end else begin
      ways_eff = CW'(ways_in_use_r);
    end
  end

  // Split the address into set and tag.
  assign addr_sh  = in_tdata >> offset_bits_r;
  assign set_mask = (ADDR_W'(1) << ib_eff) - ADDR_W'(1);
  assign set_calc = SW'(addr_sh & set_mask);
  assign tag_sh   = 6'(offset_bits_r) + 6'(ib_eff);
  assign tag_calc = (tag_sh >= 6'(ADDR_W)) ? '0 : (in_tdata >> tag_sh);

  // Sequencer: clear pass, then read row, then update row.
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign look_done = (state_r == ST_LOOK) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + SW'(1);
        if (clr_idx_r == SW'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (look_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // Access fields held for the update cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_r   <= set_calc;
      tag_r   <= tag_calc;
      store_r <= in_tuser;
    end
  end

  // Row memory: {victim pointer, dirty bits, tags}.
  assign ram_we    = (state_r == ST_CLEAR) || look_done;
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_idx_r : set_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : {new_victim, new_dirty, new_tags};

  satl_ram #(
    .DEPTH (SETS),
    .WIDTH (RW),
    .AW    (SW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (set_calc),
    .rdata (ram_rdata)
  );

  assign row_tags   = ram_rdata[TW-1:0];
  assign row_dirty  = ram_rdata[TW+WAYS-1:TW];
  assign row_victim = ram_rdata[RW-1:TW+WAYS];

  satl_way_match #(
    .WAYS (WAYS),
    .WW   (WW),
    .CW   (CW)
  ) u_match (
    .tags       (row_tags),
    .dirty      (row_dirty),
    .victim     (row_victim),
    .tag        (tag_r),
    .store      (store_r),
    .ways       (ways_eff),
    .tags_new   (new_tags),
    .dirty_new  (new_dirty),
    .victim_new (new_victim),
    .res        (look_res)
  );

  // Output register decouples the result from the next lookup.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (look_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_done) begin
      out_res_r <= look_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.dirty_evict, out_res_r.hit};

endmodule
